/* rtl/sobel_edge_magnitude_rgb_core_macros.svh */
// ============================================================================
// Assertion macros for the Sobel edge magnitude core
// Shared property wrappers with a common clock, reset and message form.
// ============================================================================
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SOBEL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define SOBEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sobel_pkg.sv */
// ============================================================================
// Sobel edge magnitude package
// Shared widths, register indexes and word types of the core.
// ============================================================================
package sobel_pkg;

    localparam int CH_BITS         = 8;
    localparam int PIX_BITS        = 3 * CH_BITS;
    localparam int ROW_BITS        = 12;
    localparam int OUT_COL_BITS    = 10;
    localparam int WIDTH_BITS      = 11;
    localparam int HEIGHT_BITS     = 12;
    localparam int CFG_DATA_BITS   = 12;
    localparam int CFG_IDX_BITS    = 1;
    localparam int GRAD_BITS       = 11;
    localparam int SUM_BITS        = 21;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int FIFO_DEPTH_DEF  = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd768;

    typedef logic [PIX_BITS-1:0] t_pix;

    typedef struct packed {
        logic [CH_BITS-1:0] in_blue;
        logic [CH_BITS-1:0] in_green;
        logic [CH_BITS-1:0] in_red;
    } t_in;

    typedef struct packed {
        logic [ROW_BITS-1:0]     out_row;
        logic [OUT_COL_BITS-1:0] out_col;
        logic [CH_BITS-1:0]      out_blue;
        logic [CH_BITS-1:0]      out_green;
        logic [CH_BITS-1:0]      out_red;
        logic                    last_of_run;
        logic                    frame_end;
    } t_out;

    // One pixel's worth of work for the back end: the updated window, the
    // input position and which of the four possible results it causes.
    typedef struct packed {
        logic [8:0][PIX_BITS-1:0] win;
        logic [ROW_BITS-1:0]      row;
        logic [OUT_COL_BITS-1:0]  col;
        logic [3:0]               mask;
    } t_job;

endpackage

/* rtl/sobel_fifo.sv */
// ============================================================================
// Sobel job queue
// Small first-in first-out queue between the front and the back end.
// ============================================================================
`include "sobel_edge_magnitude_rgb_core_macros.svh"

module sobel_fifo #(
    parameter int Depth = sobel_pkg::FIFO_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sobel_pkg::t_job i_data,
    input  logic            i_pop,
    output sobel_pkg::t_job o_data,
    output logic            o_full,
    output logic            o_empty
);
    localparam int PW = $clog2(Depth);
    localparam int CNTW = $clog2(Depth + 1);

    sobel_pkg::t_job r_mem [Depth];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CNTW-1:0] r_count;

    assign o_full  = (r_count == CNTW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SOBEL_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `SOBEL_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")
    `SOBEL_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNTW'(Depth), "queue count out of range")

endmodule

/* rtl/sobel_front.sv */
// ============================================================================
// Sobel front end
// Accepts pixels, keeps the line stores and the window, and queues jobs.
// ============================================================================
module sobel_front #(
    parameter int MaxWidth = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [sobel_pkg::WIDTH_BITS-1:0]    i_cfg_width,
    input  logic [sobel_pkg::HEIGHT_BITS-1:0]   i_cfg_height,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sobel_pkg::t_in                      i_in_data,
    input  logic                                i_full,
    output logic                                o_push,
    output sobel_pkg::t_job                     o_job
);
    localparam int CW = $clog2(MaxWidth);

    typedef enum logic [1:0] {
        ST_TAKE  = 2'b01,
        ST_WRITE = 2'b10
    } t_state;

    t_state r_state;

    sobel_pkg::t_pix mem_upper [MaxWidth];
    sobel_pkg::t_pix mem_lower [MaxWidth];

    logic [CW-1:0]                     r_col;
    logic [sobel_pkg::ROW_BITS-1:0]    r_row;
    logic [CW:0]                       r_fill;
    logic [CW-1:0]                     r_wcol;
    logic [sobel_pkg::ROW_BITS-1:0]    r_jrow;
    logic [3:0]                        r_mask;
    logic                              r_up_ok;
    logic                              r_lo_ok;
    logic                              r_hit;
    logic                              r_first;
    sobel_pkg::t_pix                   r_pix;
    sobel_pkg::t_pix                   r_rd_up;
    sobel_pkg::t_pix                   r_rd_lo;
    logic [8:0][sobel_pkg::PIX_BITS-1:0] r_win;
    logic [8:0][sobel_pkg::PIX_BITS-1:0] n_win;

    logic                  take;
    logic [31:0]           w_cfg;
    logic [31:0]           w_eff;
    logic [sobel_pkg::HEIGHT_BITS-1:0] h_m1;
    logic                  row_end;
    logic                  last_row;
    logic                  hit;
    sobel_pkg::t_pix       pix_in;

    assign o_in_ready = (r_state == ST_TAKE) && !i_full;
    assign take       = i_in_valid && o_in_ready;
    assign pix_in     = {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};

    always_comb begin
        w_cfg = 32'(i_cfg_width);
        if (w_cfg == 32'd0) begin
            w_eff = 32'd1;
        end else if (w_cfg > 32'(MaxWidth)) begin
            w_eff = 32'(MaxWidth);
        end else begin
            w_eff = w_cfg;
        end
        h_m1     = (i_cfg_height == '0) ? '0 : i_cfg_height - 1'b1;
        row_end  = 32'(r_col) >= (w_eff - 32'd1);
        last_row = r_row >= h_m1;
        // Entries at or past the fill mark were never written since reset.
        hit      = 32'(r_col) < 32'(r_fill);
    end

    // The upper store takes the old lower entry in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_up <= mem_upper[r_col];
        end
        if (r_state == ST_WRITE) begin
            mem_upper[r_wcol] <= r_hit ? r_rd_lo : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_lo          <= mem_lower[r_col];
            mem_lower[r_col] <= pix_in;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3+0] = r_first ? '0 : r_win[i*3+1];
            n_win[i*3+1] = r_first ? '0 : r_win[i*3+2];
        end
        n_win[2] = r_up_ok ? r_rd_up : '0;
        n_win[5] = r_lo_ok ? r_rd_lo : '0;
        n_win[8] = r_pix;
    end

    assign o_push     = (r_state == ST_WRITE) && (r_mask != '0);
    assign o_job.win  = n_win;
    assign o_job.row  = r_jrow;
    assign o_job.col  = sobel_pkg::OUT_COL_BITS'(r_wcol);
    assign o_job.mask = r_mask;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix     <= pix_in;
            r_wcol    <= r_col;
            r_jrow    <= r_row;
            r_hit     <= hit;
            r_first   <= (r_col == '0);
            r_mask[0] <= (r_row != '0) && (r_col != '0);
            r_mask[1] <= (r_row != '0) && row_end;
            r_mask[2] <= last_row && (r_col != '0);
            r_mask[3] <= last_row && row_end;
        end
        if (r_state == ST_WRITE) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_up_ok <= 1'b0;
            r_lo_ok <= 1'b0;
        end else begin
            case (r_state)
                ST_TAKE: begin
                    if (take) begin
                        r_up_ok <= (r_row >= sobel_pkg::ROW_BITS'(2)) && hit;
                        r_lo_ok <= (r_row != '0) && hit;
                        if (!hit) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (row_end) begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_TAKE;
                end
                default: begin
                    r_state <= ST_TAKE;
                end
            endcase
        end
    end

endmodule

/* rtl/sobel_back.sv */
// ============================================================================
// Sobel back end
// Computes gradients and rounded magnitudes for each queued result.
// ============================================================================
`include "sobel_edge_magnitude_rgb_core_macros.svh"

module sobel_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  sobel_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sobel_pkg::t_out o_out_data
);
    localparam int GB = sobel_pkg::GRAD_BITS;
    localparam int SB = sobel_pkg::SUM_BITS;
    localparam int CB = sobel_pkg::CH_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GRAD = 5'b00010,
        S_SQ   = 5'b00100,
        S_ROOT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                 r_state;
    sobel_pkg::t_job        r_job;
    logic [3:0]             r_mask;
    logic [1:0]             r_sel;
    logic signed [GB-1:0]   r_gx [3];
    logic signed [GB-1:0]   r_gy [3];
    logic [SB-1:0]          r_sum [3];
    logic [CB-1:0]          r_root [3];
    logic [2:0]             r_bit;
    sobel_pkg::t_out        r_out;

    logic [1:0]             sel;
    logic [3:0]             sel_hot;
    logic                   ro;
    logic                   co;
    logic [CB-1:0]          sw [9];
    logic [CB+1:0]          a_pos;
    logic [CB+1:0]          a_neg;
    logic [CB+1:0]          b_pos;
    logic [CB+1:0]          b_neg;
    logic signed [GB-1:0]   gx [3];
    logic signed [GB-1:0]   gy [3];
    logic [CB-1:0]          n_root [3];
    logic [CB-1:0]          trial;
    logic [2*CB-1:0]        prod;
    logic signed [2*GB-1:0] sqx;
    logic signed [2*GB-1:0] sqy;
    logic [SB-1:0]          n_sum [3];

    always_comb begin
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        sel_hot = 4'b0001 << sel;
        ro = sel[1];
        co = sel[0];
    end

    // Gradients over the window shifted down or right; shifted-out taps are zero.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i + int'(ro) <= 2) && (j + int'(co) <= 2)) begin
                        sw[i*3+j] = r_job.win[(i + int'(ro)) * 3 + j + int'(co)][ch*CB +: CB];
                    end else begin
                        sw[i*3+j] = '0;
                    end
                end
            end
            a_pos = (CB+2)'(sw[2]) + {1'b0, sw[5], 1'b0} + (CB+2)'(sw[8]);
            a_neg = (CB+2)'(sw[0]) + {1'b0, sw[3], 1'b0} + (CB+2)'(sw[6]);
            b_pos = (CB+2)'(sw[6]) + {1'b0, sw[7], 1'b0} + (CB+2)'(sw[8]);
            b_neg = (CB+2)'(sw[0]) + {1'b0, sw[1], 1'b0} + (CB+2)'(sw[2]);
            gx[ch] = $signed({1'b0, a_pos}) - $signed({1'b0, a_neg});
            gy[ch] = $signed({1'b0, b_pos}) - $signed({1'b0, b_neg});
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sqx       = r_gx[ch] * r_gx[ch];
            sqy       = r_gy[ch] * r_gy[ch];
            n_sum[ch] = SB'(sqx) + SB'(sqy);
        end
    end

    // One bit of the root per cycle: largest k with k*(k-1) below the sum.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            trial = r_root[ch] | (CB'(1) << r_bit);
            prod  = trial * (trial - 1'b1);
            n_root[ch] = (SB'(prod) < r_sum[ch]) ? trial : r_root[ch];
        end
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                end
            end
            S_GRAD: begin
                r_sel <= sel;
                for (int ch = 0; ch < 3; ch++) begin
                    r_gx[ch] <= gx[ch];
                    r_gy[ch] <= gy[ch];
                end
            end
            S_SQ: begin
                r_bit <= 3'd7;
                for (int ch = 0; ch < 3; ch++) begin
                    r_sum[ch]  <= n_sum[ch];
                    r_root[ch] <= '0;
                end
            end
            S_ROOT: begin
                r_bit <= r_bit - 1'b1;
                for (int ch = 0; ch < 3; ch++) begin
                    r_root[ch] <= n_root[ch];
                end
                if (r_bit == '0) begin
                    r_out.out_row     <= r_sel[1] ? r_job.row : r_job.row - 1'b1;
                    r_out.out_col     <= r_sel[0] ? r_job.col : r_job.col - 1'b1;
                    r_out.out_blue    <= n_root[0];
                    r_out.out_green   <= n_root[1];
                    r_out.out_red     <= n_root[2];
                    r_out.last_of_run <= (r_mask & ~(4'b0001 << r_sel)) == '0;
                    r_out.frame_end   <= (r_sel == 2'd3);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_mask  <= i_job.mask;
                        r_state <= S_GRAD;
                    end
                end
                S_GRAD: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_mask  <= r_mask & ~(4'b0001 << r_sel);
                        r_state <= r_out.last_of_run ? S_IDLE : S_GRAD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SOBEL_ASSERT_ALWAYS(a_frame_end_last, i_clk, i_rst_n, !(o_out_valid && r_out.frame_end) || r_out.last_of_run, "frame end not last of run")
    `SOBEL_ASSERT_ALWAYS(a_busy_has_work, i_clk, i_rst_n, (r_state == S_IDLE) || (r_mask != '0), "back end busy with no pending result")
    `SOBEL_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_out_valid && i_out_ready && r_out.last_of_run, r_state == S_IDLE, "back end not idle after last word")
    `SOBEL_ASSERT_ALWAYS(a_sel_pending, i_clk, i_rst_n, !o_out_valid || ((r_mask & sel_hot) != '0 && sel == r_sel), "word for a result that is not pending")

endmodule

/* rtl/sobel_edge_magnitude_rgb_core.sv */
// ============================================================================
// Sobel edge magnitude core, RGB
// Streaming 3x3 Sobel gradient magnitude per color channel with line stores.
// ============================================================================
// Usage: pixels enter in raster order on the input channel (i_in_valid,
// o_in_ready, i_in_data); a word moves when valid and ready are both high.
// Result words leave on the output channel (o_out_valid, i_out_ready,
// o_out_data), one row and one column behind the input; a pixel at a row end
// or in the last row also flushes the pending border results, so one pixel
// causes zero to four words. last_of_run marks the final word of a pixel and
// frame_end the word of the bottom-right pixel.
// Frame size is set through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Flow: the front end takes a pixel, then writes back the upper store, so it
// cannot take the next pixel before that (line store read, then write-back).
// The back end pops a job, then for each result word runs gradient, squares,
// an 8-step bit-serial root that sets the rate, then the output handshake.
// A small job queue decouples the ends. A word passes the front end's write
// state, the queue, and the back end's idle, gradient, squares and root states.
// Reset returns the frame position to the top-left pixel and marks the line
// stores empty (a fill mark, no clearing pass), so there is no start-up wait.
// When the receiver stalls, the output word holds, the queue fills, and then
// o_in_ready drops until the back end frees a slot.
// ============================================================================
module sobel_edge_magnitude_rgb_core #(
    parameter int MaxWidth  = sobel_pkg::MAX_WIDTH_DEF,
    parameter int FifoDepth = sobel_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  sobel_pkg::t_in                        i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output sobel_pkg::t_out                       o_out_data
);
    logic [sobel_pkg::WIDTH_BITS-1:0]  r_image_width;
    logic [sobel_pkg::HEIGHT_BITS-1:0] r_image_height;

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    sobel_pkg::t_job job_in;
    sobel_pkg::t_job job_out;

    // Frame size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sobel_pkg::WIDTH_RESET;
            r_image_height <= sobel_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sobel_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[sobel_pkg::WIDTH_BITS-1:0];
                end
                sobel_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[sobel_pkg::HEIGHT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end owns the position, the line stores and the window.
    sobel_front #(
        .MaxWidth(MaxWidth)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_width (r_image_width),
        .i_cfg_height(r_image_height),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    // Jobs carry a full window snapshot, so the ends run independently.
    sobel_fifo #(
        .Depth(FifoDepth)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .i_pop  (pop),
        .o_data (job_out),
        .o_full (full),
        .o_empty(empty)
    );

    // The back end turns each job into its result words, in order.
    sobel_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

/* tb/sobel_edge_magnitude_rgb_core_tb.sv */
// ============================================================================
// Testbench for the Sobel edge magnitude core, RGB
// Streams raster pixels through frames of many sizes, predicts every result
// word with a behavioral model of the line stores and window, and compares
// the words field by field under random input gaps and output stalls.
// ============================================================================
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_core_tb;
    import sobel_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 230;

    typedef enum logic [1:0] {
        STEP_PIX,
        STEP_PIX_TYPED,
        STEP_CFG
    } t_step_kind;

    typedef struct {
        t_step_kind                 kind;
        logic [CFG_IDX_BITS-1:0]    idx;
        logic [CFG_DATA_BITS-1:0]   data;
        t_in                        px;
    } t_step;

    // A 1x1 frame has no neighbours, so the gradient is zero and the single
    // word closes both the pixel and the frame.
    localparam t_out LONE_PIXEL_WORD = '{out_row: '0, out_col: '0, out_blue: '0,
                                         out_green: '0, out_red: '0,
                                         last_of_run: 1'b1, frame_end: 1'b1};

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    t_in            i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    t_out           o_out_data;

    sobel_edge_magnitude_rgb_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: line stores, window, frame position and frame size.
    // ------------------------------------------------------------------------
    t_pix        row_above2 [MAX_WIDTH_DEF];
    t_pix        row_above1 [MAX_WIDTH_DEF];
    t_pix        win_pix [9];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [WIDTH_BITS-1:0]  frame_w;
    logic [HEIGHT_BITS-1:0] frame_h;

    t_out        pending_words[$];
    int          err_cnt = 0;
    int          words_seen = 0;
    int          pixels_sent = 0;
    int          burst_left = 0;
    bit          timed_out = 1'b0;
    bit          hold_req = 1'b0;

    // Rounded square root: largest k with k*(k-1) below the sum, capped at 255.
    function automatic logic [CH_BITS-1:0] round_root(int unsigned s);
        logic [CH_BITS-1:0] res;
        res = '0;
        for (int unsigned k = 1; k <= 255; k++) begin
            if (k * (k - 1) < s) res = k[CH_BITS-1:0];
        end
        return res;
    endfunction

    // One result word from the window, shifted down by ro and right by co;
    // window cells pushed out of the 3x3 range read as zero.
    function automatic t_out gradient_word(int ro, int co, int unsigned orow,
                                           int unsigned ocol, bit fend);
        t_out w;
        logic [CH_BITS-1:0] mag [3];
        int gx, gy, v;
        for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v = 0;
                    if (i + ro <= 2 && j + co <= 2)
                        v = int'(win_pix[(i + ro) * 3 + j + co][ch*CH_BITS +: CH_BITS]);
                    gx += v * ((j == 1) ? 0 : ((j == 0) ? -1 : 1) * ((i == 1) ? 2 : 1));
                    gy += v * ((i == 1) ? 0 : ((i == 0) ? -1 : 1) * ((j == 1) ? 2 : 1));
                end
            end
            mag[ch] = round_root(gx * gx + gy * gy);
        end
        w.out_row     = orow[ROW_BITS-1:0];
        w.out_col     = ocol[OUT_COL_BITS-1:0];
        w.out_blue    = mag[0];
        w.out_green   = mag[1];
        w.out_red     = mag[2];
        w.last_of_run = 1'b0;
        w.frame_end   = fend;
        return w;
    endfunction

    // Advances the model by one pixel and returns the words it causes.
    task automatic predict_pixel(t_in px, output t_out words[$]);
        int unsigned w, h, r, c;
        t_pix pix, up, lo;
        bit row_end, last_row;
        w = (frame_w < 1) ? 1 : ((frame_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : frame_w);
        h = (frame_h < 1) ? 1 : frame_h;
        r = cur_row;
        c = (cur_col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : cur_col;
        pix = {px.in_red, px.in_green, px.in_blue};
        up = (r >= 2) ? row_above2[c] : '0;
        lo = (r >= 1) ? row_above1[c] : '0;
        row_above2[c] = row_above1[c];
        row_above1[c] = pix;
        if (c == 0) begin
            foreach (win_pix[i]) win_pix[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            win_pix[i*3]     = win_pix[i*3 + 1];
            win_pix[i*3 + 1] = win_pix[i*3 + 2];
        end
        win_pix[2] = up;
        win_pix[5] = lo;
        win_pix[8] = pix;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);
        words = {};
        if (r >= 1 && c >= 1) words.push_back(gradient_word(0, 0, r - 1, c - 1, 1'b0));
        if (r >= 1 && row_end) words.push_back(gradient_word(0, 1, r - 1, c, 1'b0));
        if (last_row && c >= 1) words.push_back(gradient_word(1, 0, r, c - 1, 1'b0));
        if (last_row && row_end) words.push_back(gradient_word(1, 1, r, c, 1'b1));
        if (words.size() > 0) words[words.size() - 1].last_of_run = 1'b1;
        if (row_end) begin
            cur_col = 0;
            cur_row = last_row ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            cur_col = c + 1;
        end
    endtask

    // Offers one pixel, in bursts with idle gaps between them, and
    // records the words it should cause once it has been taken.
    task automatic send_pixel(t_in px, bit typed);
        t_out words[$];
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        pixels_sent++;
        predict_pixel(px, words);
        if (typed) pending_words.push_back(LONE_PIXEL_WORD);
        else foreach (words[i]) pending_words.push_back(words[i]);
    endtask

    // Register writes happen only once the block has drained; a pixel with
    // no word may still be in flight, so a settle time follows.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) frame_w = data[WIDTH_BITS-1:0];
        else frame_h = data[HEIGHT_BITS-1:0];
    endtask

    function automatic t_in rand_pixel();
        t_in px;
        px.in_blue  = ($urandom_range(0, 5) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        px.in_green = ($urandom_range(0, 5) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        px.in_red   = ($urandom_range(0, 5) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Directed part: tiny frames, saturating edges, and out-of-range sizes.
    // ------------------------------------------------------------------------
    t_step dir_steps[] = '{
        '{STEP_CFG, REG_IMAGE_WIDTH, 12'd1, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd1, '0},
        '{STEP_PIX_TYPED, '0, '0, '{8'hFF, 8'hFF, 8'hFF}},
        '{STEP_PIX_TYPED, '0, '0, '{8'h00, 8'h00, 8'h00}},
        '{STEP_CFG, REG_IMAGE_WIDTH, 12'd3, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd3, '0},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'h00, 8'hFF}},
        '{STEP_PIX, '0, '0, '{8'h00, 8'hFF, 8'h00}},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'h00, 8'hFF}},
        '{STEP_PIX, '0, '0, '{8'h00, 8'hFF, 8'h00}},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'hFF, 8'hFF}},
        '{STEP_PIX, '0, '0, '{8'h00, 8'h00, 8'h00}},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'hFF, 8'hFF}},
        '{STEP_PIX, '0, '0, '{8'h00, 8'h00, 8'h00}},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'hFF, 8'hFF}},
        '{STEP_CFG, REG_IMAGE_WIDTH, 12'd0, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd0, '0},
        '{STEP_PIX_TYPED, '0, '0, '{8'hA5, 8'h5A, 8'hC3}},
        '{STEP_CFG, REG_IMAGE_WIDTH, 12'd2047, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 12'd4095, '0},
        '{STEP_PIX, '0, '0, '{8'h80, 8'h01, 8'hFE}},
        '{STEP_PIX, '0, '0, '{8'h7F, 8'hFE, 8'h01}},
        '{STEP_PIX, '0, '0, '{8'h00, 8'hFF, 8'h55}},
        '{STEP_PIX, '0, '0, '{8'hFF, 8'h00, 8'hAA}}
    };

    initial begin
        int unsigned w, h, ew, n;
        foreach (row_above2[i]) begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        foreach (win_pix[i]) win_pix[i] = '0;
        cur_row = 0;
        cur_col = 0;
        frame_w = WIDTH_RESET;
        frame_h = HEIGHT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_CFG)
                write_reg(dir_steps[i].idx, dir_steps[i].data);
            else
                send_pixel(dir_steps[i].px, dir_steps[i].kind == STEP_PIX_TYPED);
        end

        // Back pressure: the receiver holds off while a run of pixels that
        // mostly cause words is offered, so the queue fills and input stalls.
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(6));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(4));
        hold_req = 1'b1;
        repeat (24) send_pixel(rand_pixel(), 1'b0);

        // Random frames: mostly whole small frames, now and then a partial
        // frame or an extreme size, which leaves the position mid-frame.
        while (pixels_sent < ITEM_TARGET) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 5);
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
            ew = (w < 1) ? 1 : w;
            n  = (ew * ((h < 1) ? 1 : h) > 40 || $urandom_range(0, 4) == 0)
                 ? $urandom_range(1, 20) : ew * ((h < 1) ? 1 : h);
            repeat (n) send_pixel(rand_pixel(), 1'b0);
        end

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && !timed_out) begin
            $display("sobel_edge_magnitude_rgb_core_tb OK");
        end else begin
            $display("sobel_edge_magnitude_rgb_core_tb NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each word against the oldest expectation, stalls on
    // its own pattern, and once holds off long enough to back up the input.
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n) begin
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sobel_edge_magnitude_rgb_core_tb NOT OK");
                timed_out = 1'b1;
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                if (pending_words.size() == 0) begin
                    $error("result word with no expectation pending");
                    err_cnt++;
                end else begin
                    exp_w = pending_words.pop_front();
                    check_field("out_row", exp_w.out_row, o_out_data.out_row);
                    check_field("out_col", exp_w.out_col, o_out_data.out_col);
                    check_field("out_blue", exp_w.out_blue, o_out_data.out_blue);
                    check_field("out_green", exp_w.out_green, o_out_data.out_green);
                    check_field("out_red", exp_w.out_red, o_out_data.out_red);
                    check_field("last_of_run", exp_w.last_of_run, o_out_data.last_of_run);
                    check_field("frame_end", exp_w.frame_end, o_out_data.frame_end);
                end
            end
        end
        if (!hold_done && hold_req) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 80);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

endmodule
